@@ rtl/rlptok_pkg.sv @@
// Shared types and constants for the transaction field tokenizer.
package rlptok_pkg;

   localparam logic [7:0] TYPE_ACCESS_LIST = 8'h01;
   localparam logic [7:0] TYPE_FEE_MARKET  = 8'h02;
   localparam logic [7:0] SINGLE_MAX       = 8'h7f;
   localparam logic [7:0] STR_BASE         = 8'h80;
   localparam logic [7:0] SHORT_STR_MAX    = 8'hb7;
   localparam logic [7:0] LONG_STR_MAX     = 8'hbf;
   localparam logic [7:0] LIST_BASE        = 8'hc0;
   localparam logic [7:0] SHORT_LIST_MAX   = 8'hf7;

   localparam logic [2:0] ROLE_PREFIX    = 3'd0;
   localparam logic [2:0] ROLE_LIST_HDR  = 3'd1;
   localparam logic [2:0] ROLE_LIST_LEN  = 3'd2;
   localparam logic [2:0] ROLE_ITEM_HDR  = 3'd3;
   localparam logic [2:0] ROLE_ITEM_LEN  = 3'd4;
   localparam logic [2:0] ROLE_CONTENT   = 3'd5;
   localparam logic [2:0] ROLE_TRAILING  = 3'd6;

   localparam logic [1:0] KIND_LEGACY     = 2'd0;
   localparam logic [1:0] KIND_FEE_MARKET = 2'd2;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_OVERRUN   = 3'd1;
   localparam logic [2:0] ERR_SHORT     = 3'd2;
   localparam logic [2:0] ERR_TOO_WIDE  = 3'd3;
   localparam logic [2:0] ERR_FEW       = 3'd4;

   localparam logic [3:0] FIELD_MAX = 4'hf;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } in_word_type;

   typedef struct packed {
      logic [2:0]  byte_role;
      logic [3:0]  field_index;
      logic [1:0]  tx_kind;
      logic        item_is_list;
      logic [31:0] item_length;
      logic [7:0]  value_byte;
      logic        item_done;
      logic        list_done;
      logic [2:0]  error_code;
   } out_word_type;

endpackage

@@ rtl/rlptok_input_stage.sv @@
// Input register stage: holds one accepted byte until the parser takes it.
module rlptok_input_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  rlptok_pkg::in_word_type   req_word,
   output logic                      req_ready,
   input  logic                      take,
   output logic                      hold_valid,
   output rlptok_pkg::in_word_type   hold_word
);

   logic                    valid_ff;
   logic                    valid_in;
   rlptok_pkg::in_word_type word_ff;

   assign req_ready  = !valid_ff || take;
   assign valid_in   = (valid_ff && !take) || (req_valid && req_ready);
   assign hold_valid = valid_ff;
   assign hold_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         word_ff <= req_word;
      end
   end

endmodule

@@ rtl/rlptok_parser.sv @@
// Tokenizer state, per-byte classification and the result register.
module rlptok_parser #(
   parameter int LEN_BITS          = 32,
   parameter int LEGACY_FIELDS     = 9,
   parameter int FEE_MARKET_FIELDS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      hold_valid,
   input  rlptok_pkg::in_word_type   hold_word,
   output logic                      take,
   input  logic                      out_ready,
   output logic                      out_valid,
   output rlptok_pkg::out_word_type  out_word
);

   localparam int WideBits = (LEN_BITS > 32) ? LEN_BITS : 32;

   typedef enum logic [2:0] {
      PH_START, PH_LHDR, PH_LLEN, PH_HDR, PH_ILEN, PH_BODY, PH_TRAIL
   } phase_type;

   phase_type             phase_ff, phase_in, cur_phase;
   logic [1:0]            kind_ff, kind_in, cur_kind;
   logic [LEN_BITS-1:0]   list_rem_ff, list_rem_in, cur_list_rem;
   logic [LEN_BITS-1:0]   item_rem_ff, item_rem_in, cur_item_rem;
   logic [LEN_BITS-1:0]   accum_ff, accum_in, cur_accum;
   logic [3:0]            left_ff, left_in, cur_left;
   logic [3:0]            count_ff, count_in, cur_count;
   logic                  long_list_ff, long_list_in, cur_long_list;
   logic [2:0]            err_ff, err_in, cur_err;
   logic                  out_valid_ff, out_valid_in;
   rlptok_pkg::out_word_type out_word_ff, out_word_in;

   logic [7:0]            b;
   logic                  is_prefix, do_lhdr;
   logic                  take_ok;
   logic [LEN_BITS+7:0]   joined;
   logic [LEN_BITS-1:0]   shifted;
   logic [3:0]            left_dec;
   logic [LEN_BITS-1:0]   list_dec;
   logic [LEN_BITS-1:0]   item_dec;
   logic [7:0]            short_diff;
   logic [3:0]            long_lb;
   logic                  st_req, fin_req, end_req, in_list;
   logic [LEN_BITS-1:0]   st_n;
   logic                  st_list;
   logic [3:0]            need;
   logic [2:0]            new_err;
   logic [2:0]            o_role;
   logic [3:0]            o_idx;
   logic                  o_islist, o_idone, o_ldone;
   logic [LEN_BITS-1:0]   o_len;
   logic [WideBits-1:0]   len_wide;

   assign b = hold_word.data_byte;

   assign cur_phase     = hold_word.first_byte ? PH_START : phase_ff;
   assign cur_kind      = hold_word.first_byte ? rlptok_pkg::KIND_LEGACY : kind_ff;
   assign cur_list_rem  = hold_word.first_byte ? '0 : list_rem_ff;
   assign cur_item_rem  = hold_word.first_byte ? '0 : item_rem_ff;
   assign cur_accum     = hold_word.first_byte ? '0 : accum_ff;
   assign cur_left      = hold_word.first_byte ? 4'd0 : left_ff;
   assign cur_count     = hold_word.first_byte ? 4'd0 : count_ff;
   assign cur_long_list = hold_word.first_byte ? 1'b0 : long_list_ff;
   assign cur_err       = hold_word.first_byte ? rlptok_pkg::ERR_NONE : err_ff;

   assign is_prefix = (b == rlptok_pkg::TYPE_ACCESS_LIST) || (b == rlptok_pkg::TYPE_FEE_MARKET);
   assign do_lhdr   = ((cur_phase == PH_START) && !is_prefix) || (cur_phase == PH_LHDR);

   assign take_ok  = (cur_accum[LEN_BITS-1 -: 8] == 8'd0);
   assign joined   = {cur_accum, b};
   assign shifted  = joined[LEN_BITS-1:0];
   assign left_dec = (cur_left != 4'd0) ? cur_left - 4'd1 : cur_left;
   assign list_dec = (cur_list_rem != '0) ? cur_list_rem - LEN_BITS'(1) : cur_list_rem;
   assign item_dec = (cur_item_rem != '0) ? cur_item_rem - LEN_BITS'(1) : cur_item_rem;

   assign short_diff = (b <= rlptok_pkg::SHORT_STR_MAX) ? b - rlptok_pkg::STR_BASE
                                                        : b - rlptok_pkg::LIST_BASE;
   assign long_lb    = (b <= rlptok_pkg::LONG_STR_MAX) ? 4'(b - rlptok_pkg::SHORT_STR_MAX)
                                                       : 4'(b - rlptok_pkg::SHORT_LIST_MAX);

   always_comb begin
      phase_in     = cur_phase;
      kind_in      = cur_kind;
      list_rem_in  = cur_list_rem;
      item_rem_in  = cur_item_rem;
      accum_in     = cur_accum;
      left_in      = cur_left;
      count_in     = cur_count;
      long_list_in = cur_long_list;
      err_in       = cur_err;
      o_role   = rlptok_pkg::ROLE_TRAILING;
      o_idx    = 4'd0;
      o_islist = 1'b0;
      o_idone  = 1'b0;
      o_ldone  = 1'b0;
      o_len    = '0;
      new_err  = rlptok_pkg::ERR_NONE;
      in_list  = 1'b0;
      st_req   = 1'b0;
      fin_req  = 1'b0;
      end_req  = 1'b0;
      st_n     = shifted;
      st_list  = cur_long_list;
      need     = 4'd0;

      unique case (cur_phase)
         PH_START: begin
            if (is_prefix) begin
               kind_in  = b[1:0];
               o_role   = rlptok_pkg::ROLE_PREFIX;
               phase_in = PH_LHDR;
            end else begin
               kind_in = rlptok_pkg::KIND_LEGACY;
            end
         end
         PH_LHDR: begin
            kind_in = cur_kind;
         end
         PH_LLEN: begin
            o_role = rlptok_pkg::ROLE_LIST_LEN;
            if (!take_ok) begin
               new_err = rlptok_pkg::ERR_TOO_WIDE;
            end else begin
               accum_in = shifted;
               left_in  = left_dec;
               if (left_dec == 4'd0) begin
                  list_rem_in = shifted;
                  o_len       = shifted;
                  phase_in    = PH_HDR;
                  end_req     = (shifted == '0);
               end
            end
         end
         PH_HDR: begin
            in_list     = 1'b1;
            o_idx       = cur_count;
            list_rem_in = list_dec;
            o_role      = rlptok_pkg::ROLE_ITEM_HDR;
            o_islist    = (b >= rlptok_pkg::LIST_BASE);
            long_list_in = (b >= rlptok_pkg::LIST_BASE);
            if (b <= rlptok_pkg::SINGLE_MAX) begin
               o_role  = rlptok_pkg::ROLE_CONTENT;
               o_len   = LEN_BITS'(1);
               fin_req = 1'b1;
            end else if ((b <= rlptok_pkg::SHORT_STR_MAX) ||
                         ((b >= rlptok_pkg::LIST_BASE) && (b <= rlptok_pkg::SHORT_LIST_MAX))) begin
               st_req  = 1'b1;
               st_n    = LEN_BITS'(short_diff);
               st_list = (b >= rlptok_pkg::LIST_BASE);
            end else if (LEN_BITS'(long_lb) > list_dec) begin
               new_err = rlptok_pkg::ERR_OVERRUN;
            end else begin
               left_in  = long_lb;
               accum_in = '0;
               phase_in = PH_ILEN;
            end
         end
         PH_ILEN: begin
            in_list     = 1'b1;
            o_role      = rlptok_pkg::ROLE_ITEM_LEN;
            o_idx       = cur_count;
            o_islist    = cur_long_list;
            list_rem_in = list_dec;
            if (!take_ok) begin
               new_err = rlptok_pkg::ERR_TOO_WIDE;
            end else begin
               accum_in = shifted;
               left_in  = left_dec;
               st_req   = (left_dec == 4'd0);
            end
         end
         PH_BODY: begin
            in_list     = 1'b1;
            o_role      = rlptok_pkg::ROLE_CONTENT;
            o_idx       = cur_count;
            o_islist    = cur_long_list;
            o_len       = cur_accum;
            list_rem_in = list_dec;
            item_rem_in = item_dec;
            fin_req     = (item_dec == '0);
         end
         default: begin
            o_role = rlptok_pkg::ROLE_TRAILING;
            o_idx  = cur_count;
         end
      endcase

      if (do_lhdr) begin
         o_role = rlptok_pkg::ROLE_LIST_HDR;
         if (b > rlptok_pkg::SHORT_LIST_MAX) begin
            left_in  = 4'(b - rlptok_pkg::SHORT_LIST_MAX);
            accum_in = '0;
            phase_in = PH_LLEN;
         end else if (b >= rlptok_pkg::LIST_BASE) begin
            list_rem_in = LEN_BITS'(8'(b - rlptok_pkg::LIST_BASE));
            o_len       = LEN_BITS'(8'(b - rlptok_pkg::LIST_BASE));
            phase_in    = PH_HDR;
            end_req     = (b == rlptok_pkg::LIST_BASE);
         end else begin
            list_rem_in = '0;
            end_req     = 1'b1;
         end
      end

      if (st_req) begin
         long_list_in = st_list;
         o_islist     = st_list;
         o_len        = st_n;
         accum_in     = st_n;
         if (st_n > list_dec) begin
            new_err = rlptok_pkg::ERR_OVERRUN;
         end else if (st_n == '0) begin
            fin_req = 1'b1;
         end else begin
            item_rem_in = st_n;
            phase_in    = PH_BODY;
         end
      end

      if (fin_req) begin
         o_idone  = 1'b1;
         count_in = (cur_count != rlptok_pkg::FIELD_MAX) ? cur_count + 4'd1 : cur_count;
         phase_in = PH_HDR;
      end

      if ((new_err == rlptok_pkg::ERR_NONE) && in_list && (list_rem_in == '0)) begin
         end_req = 1'b1;
      end

      if (end_req) begin
         o_ldone  = 1'b1;
         phase_in = PH_TRAIL;
         if (kind_in == rlptok_pkg::KIND_LEGACY) begin
            need = 4'(LEGACY_FIELDS);
         end else if (kind_in == rlptok_pkg::KIND_FEE_MARKET) begin
            need = 4'(FEE_MARKET_FIELDS);
         end
         if ((count_in < need) && (new_err == rlptok_pkg::ERR_NONE)) begin
            new_err = rlptok_pkg::ERR_FEW;
         end
      end

      if (new_err != rlptok_pkg::ERR_NONE) begin
         if (cur_err == rlptok_pkg::ERR_NONE) begin
            err_in = new_err;
         end
         phase_in = PH_TRAIL;
      end

      if (hold_word.last_byte && (phase_in != PH_TRAIL) && (err_in == rlptok_pkg::ERR_NONE)) begin
         err_in = rlptok_pkg::ERR_SHORT;
      end

      len_wide = WideBits'(o_len);
      out_word_in.byte_role    = o_role;
      out_word_in.field_index  = o_idx;
      out_word_in.tx_kind      = kind_in;
      out_word_in.item_is_list = o_islist;
      out_word_in.item_length  = len_wide[31:0];
      out_word_in.value_byte   = b;
      out_word_in.item_done    = o_idone;
      out_word_in.list_done    = o_ldone;
      out_word_in.error_code   = err_in;

      if (hold_word.last_byte) begin
         phase_in     = PH_START;
         kind_in      = rlptok_pkg::KIND_LEGACY;
         list_rem_in  = '0;
         item_rem_in  = '0;
         accum_in     = '0;
         left_in      = 4'd0;
         count_in     = 4'd0;
         long_list_in = 1'b0;
         err_in       = rlptok_pkg::ERR_NONE;
      end
   end

   assign take         = hold_valid && (!out_valid_ff || out_ready);
   assign out_valid_in = take || (out_valid_ff && !out_ready);
   assign out_valid    = out_valid_ff;
   assign out_word     = out_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         kind_ff      <= rlptok_pkg::KIND_LEGACY;
         list_rem_ff  <= '0;
         item_rem_ff  <= '0;
         accum_ff     <= '0;
         left_ff      <= 4'd0;
         count_ff     <= 4'd0;
         long_list_ff <= 1'b0;
         err_ff       <= rlptok_pkg::ERR_NONE;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            phase_ff     <= phase_in;
            kind_ff      <= kind_in;
            list_rem_ff  <= list_rem_in;
            item_rem_ff  <= item_rem_in;
            accum_ff     <= accum_in;
            left_ff      <= left_in;
            count_ff     <= count_in;
            long_list_ff <= long_list_in;
            err_ff       <= err_in;
            out_word_ff  <= out_word_in;
         end
      end
   end

endmodule

@@ rtl/rlp_transaction_field_tokenizer.sv @@
// Top level: byte-stream tokenizer for raw signed transactions.
//
// Input channel (req_): one transaction byte per word; req_tuser marks the
// first byte of a transaction and req_tlast the final one.
// Result channel (rsp_): exactly one result word per input word, in order,
// carrying the byte's role, field index, transaction kind, item length,
// the byte itself, item/list end flags and the latched error code.
// Each byte is held in the input register, then classified into the result
// register, whose output is the result word.
// Throughput: one byte per cycle while rsp_tready is high; each byte needs
// only compares, a shift-or of the length accumulator and counter
// decrements in one register stage.
// Reset clears the tokenizer state to expect a type prefix or list header
// and empties both registers. While the receiver holds rsp_tready low the
// result register holds its word and the input register still takes one
// more byte; further bytes then wait on req_tready.
module rlp_transaction_field_tokenizer #(
   parameter int LEN_BITS          = 32,
   parameter int LEGACY_FIELDS     = 9,
   parameter int FEE_MARKET_FIELDS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic        req_tuser,   // first_byte[0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // field_index[3:0], item_length[35:4], value_byte[43:36],
                                    // item_done[44], error_code[47:45]
   output logic [5:0]  rsp_tuser,   // byte_role[2:0], tx_kind[4:3], item_is_list[5]
   output logic        rsp_tlast
);

   rlptok_pkg::in_word_type  req_word;
   rlptok_pkg::in_word_type  hold_word;
   rlptok_pkg::out_word_type out_word;
   logic                     hold_valid;
   logic                     take;

   assign req_word.data_byte  = req_tdata;
   assign req_word.first_byte = req_tuser;
   assign req_word.last_byte  = req_tlast;

   rlptok_input_stage u_input_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_word   (req_word),
      .req_ready  (req_tready),
      .take       (take),
      .hold_valid (hold_valid),
      .hold_word  (hold_word)
   );

   rlptok_parser #(
      .LEN_BITS          (LEN_BITS),
      .LEGACY_FIELDS     (LEGACY_FIELDS),
      .FEE_MARKET_FIELDS (FEE_MARKET_FIELDS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .hold_valid (hold_valid),
      .hold_word  (hold_word),
      .take       (take),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_word   (out_word)
   );

   assign rsp_tdata = {out_word.error_code, out_word.item_done, out_word.value_byte,
                       out_word.item_length, out_word.field_index};
   assign rsp_tuser = {out_word.item_is_list, out_word.tx_kind, out_word.byte_role};
   assign rsp_tlast = out_word.list_done;

endmodule

@@ tb/rlptok_token_checker.sv @@
// Watches both channels of the tokenizer, predicts every result word and compares it.
`timescale 1ns / 100ps

module rlptok_token_checker
   import rlptok_pkg::*;
#(
   parameter int LEN_BITS          = 32,
   parameter int LEGACY_FIELDS     = 9,
   parameter int FEE_MARKET_FIELDS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic [5:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending_words,
   output int          words_checked
);

   typedef enum logic [2:0] {
      AT_START, AT_LIST_HDR, AT_LIST_LEN, AT_ITEM_HDR, AT_ITEM_LEN, AT_BODY, AT_TRAIL
   } scan_state_type;

   scan_state_type st;
   logic [1:0]   kind_q;
   logic [63:0]  list_left;
   logic [63:0]  item_left;
   logic [63:0]  len_acc;
   logic [3:0]   len_bytes_left;
   logic [3:0]   fields_done;
   logic         long_list_q;
   logic [2:0]   err_q;

   out_word_type w;
   logic [2:0]   err_new;
   out_word_type expected_words[$];

   function automatic void clear_scan();
      st             = AT_START;
      kind_q         = KIND_LEGACY;
      list_left      = '0;
      item_left      = '0;
      len_acc        = '0;
      len_bytes_left = '0;
      fields_done    = '0;
      long_list_q    = 1'b0;
      err_q          = ERR_NONE;
   endfunction

   function automatic void close_list();
      int need;
      need = 0;
      w.list_done = 1'b1;
      st = AT_TRAIL;
      if (kind_q == KIND_LEGACY) begin
         need = LEGACY_FIELDS;
      end else if (kind_q == KIND_FEE_MARKET) begin
         need = FEE_MARKET_FIELDS;
      end
      if (fields_done < need && err_new == ERR_NONE) begin
         err_new = ERR_FEW;
      end
   endfunction

   function automatic void close_item();
      w.item_done = 1'b1;
      if (fields_done < FIELD_MAX) begin
         fields_done++;
      end
      st = AT_ITEM_HDR;
   endfunction

   function automatic void open_item(logic [63:0] n, logic is_list);
      long_list_q    = is_list;
      w.item_is_list = is_list;
      w.item_length  = n[31:0];
      len_acc        = n;
      if (n > list_left) begin
         err_new = ERR_OVERRUN;
      end else if (n == 0) begin
         close_item();
      end else begin
         item_left = n;
         st = AT_BODY;
      end
   endfunction

   function automatic void outer_header(logic [7:0] b);
      w.byte_role = ROLE_LIST_HDR;
      if (b > SHORT_LIST_MAX) begin
         len_bytes_left = 4'(b - SHORT_LIST_MAX);
         len_acc = '0;
         st = AT_LIST_LEN;
      end else if (b >= LIST_BASE) begin
         list_left = 64'(b - LIST_BASE);
         w.item_length = list_left[31:0];
         st = AT_ITEM_HDR;
         if (list_left == 0) begin
            close_list();
         end
      end else begin
         list_left = '0;
         close_list();
      end
   endfunction

   function automatic logic shift_len(logic [7:0] b);
      if ((len_acc >> (LEN_BITS - 8)) != 0) begin
         err_new = ERR_TOO_WIDE;
         return 1'b0;
      end
      len_acc = (len_acc << 8) | 64'(b);
      if (len_bytes_left > 0) begin
         len_bytes_left--;
      end
      return 1'b1;
   endfunction

   function automatic out_word_type predict_word(logic [7:0] b, logic first, logic last);
      logic       in_list;
      logic [3:0] lb;
      if (first) begin
         clear_scan();
      end
      w = '0;
      w.byte_role  = ROLE_TRAILING;
      w.value_byte = b;
      err_new = ERR_NONE;
      in_list = 1'b0;
      case (st)
         AT_START: begin
            if (b == TYPE_ACCESS_LIST || b == TYPE_FEE_MARKET) begin
               kind_q = b[1:0];
               w.byte_role = ROLE_PREFIX;
               st = AT_LIST_HDR;
            end else begin
               kind_q = KIND_LEGACY;
               outer_header(b);
            end
         end
         AT_LIST_HDR: outer_header(b);
         AT_LIST_LEN: begin
            w.byte_role = ROLE_LIST_LEN;
            if (shift_len(b) && len_bytes_left == 0) begin
               list_left = len_acc;
               w.item_length = list_left[31:0];
               st = AT_ITEM_HDR;
               if (list_left == 0) begin
                  close_list();
               end
            end
         end
         AT_ITEM_HDR: begin
            in_list = 1'b1;
            w.field_index = fields_done;
            w.byte_role = ROLE_ITEM_HDR;
            if (list_left > 0) begin
               list_left--;
            end
            if (b <= SINGLE_MAX) begin
               w.byte_role = ROLE_CONTENT;
               w.item_length = 32'd1;
               long_list_q = 1'b0;
               close_item();
            end else if (b <= SHORT_STR_MAX) begin
               open_item(64'(b - STR_BASE), 1'b0);
            end else if (b > LONG_STR_MAX && b <= SHORT_LIST_MAX) begin
               open_item(64'(b - LIST_BASE), 1'b1);
            end else begin
               long_list_q = (b > SHORT_LIST_MAX);
               lb = long_list_q ? 4'(b - SHORT_LIST_MAX) : 4'(b - SHORT_STR_MAX);
               w.item_is_list = long_list_q;
               if (64'(lb) > list_left) begin
                  err_new = ERR_OVERRUN;
               end else begin
                  len_bytes_left = lb;
                  len_acc = '0;
                  st = AT_ITEM_LEN;
               end
            end
         end
         AT_ITEM_LEN: begin
            in_list = 1'b1;
            w.byte_role = ROLE_ITEM_LEN;
            w.field_index = fields_done;
            w.item_is_list = long_list_q;
            if (list_left > 0) begin
               list_left--;
            end
            if (shift_len(b) && len_bytes_left == 0) begin
               open_item(len_acc, long_list_q);
            end
         end
         AT_BODY: begin
            in_list = 1'b1;
            w.byte_role = ROLE_CONTENT;
            w.field_index = fields_done;
            w.item_is_list = long_list_q;
            w.item_length = len_acc[31:0];
            if (list_left > 0) begin
               list_left--;
            end
            if (item_left > 0) begin
               item_left--;
            end
            if (item_left == 0) begin
               close_item();
            end
         end
         default: begin
            w.byte_role = ROLE_TRAILING;
            w.field_index = fields_done;
         end
      endcase
      if (err_new == ERR_NONE && in_list && list_left == 0) begin
         close_list();
      end
      if (err_new != ERR_NONE) begin
         if (err_q == ERR_NONE) begin
            err_q = err_new;
         end
         st = AT_TRAIL;
      end
      if (last && st != AT_TRAIL && err_q == ERR_NONE) begin
         err_q = ERR_SHORT;
      end
      w.tx_kind = kind_q;
      w.error_code = err_q;
      if (last) begin
         clear_scan();
      end
      return w;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      out_word_type want;
      out_word_type got;
      if (reset) begin
         clear_scan();
         expected_words.delete();
         fail_count    = 0;
         pending_words = 0;
         words_checked = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_words.push_back(predict_word(req_tdata, req_tuser, req_tlast));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.field_index  = rsp_tdata[3:0];
            got.item_length  = rsp_tdata[35:4];
            got.value_byte   = rsp_tdata[43:36];
            got.item_done    = rsp_tdata[44];
            got.error_code   = rsp_tdata[47:45];
            got.byte_role    = rsp_tuser[2:0];
            got.tx_kind      = rsp_tuser[4:3];
            got.item_is_list = rsp_tuser[5];
            got.list_done    = rsp_tlast;
            if (expected_words.size() == 0) begin
               $error("result word 0x%0h arrived with nothing expected", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("byte_role", 32'(want.byte_role), 32'(got.byte_role));
               check_field("field_index", 32'(want.field_index), 32'(got.field_index));
               check_field("tx_kind", 32'(want.tx_kind), 32'(got.tx_kind));
               check_field("item_is_list", 32'(want.item_is_list), 32'(got.item_is_list));
               check_field("item_length", want.item_length, got.item_length);
               check_field("value_byte", 32'(want.value_byte), 32'(got.value_byte));
               check_field("item_done", 32'(want.item_done), 32'(got.item_done));
               check_field("list_done", 32'(want.list_done), 32'(got.list_done));
               check_field("error_code", 32'(want.error_code), 32'(got.error_code));
            end
            words_checked++;
         end
         pending_words = expected_words.size();
      end
   end

endmodule

@@ tb/testbench.sv @@
// Top of the tokenizer testbench: clock, reset, byte stimulus and the final verdict.
`timescale 1ns / 100ps

module testbench;
   import rlptok_pkg::*;

   localparam int LEGACY_FIELDS     = 9;
   localparam int FEE_MARKET_FIELDS = 12;
   localparam int TARGET_BYTES      = 1550;
   localparam int QUIET_BYTES       = 250;
   localparam int CYCLE_LIMIT       = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [5:0]  rsp_tuser;
   logic        rsp_tlast;

   int fail_count;
   int pending_words;
   int words_checked;

   logic       quiet = 1'b0;
   int         rsp_stall_left = 0;
   int         cycle_count = 0;
   int         bytes_sent = 0;
   int         tx_count = 0;
   int         noise_count = 0;
   logic [7:0] tx_bytes[$];
   logic [7:0] list_payload[$];

   rlp_transaction_field_tokenizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   rlptok_token_checker #(
      .LEGACY_FIELDS     (LEGACY_FIELDS),
      .FEE_MARKET_FIELDS (FEE_MARKET_FIELDS)
   ) token_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending_words (pending_words),
      .words_checked (words_checked)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // stall the result side in short bursts
   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic put_byte(input logic [7:0] b, input logic f, input logic l);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= f;
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_tx(input logic with_first);
      foreach (tx_bytes[i]) begin
         put_byte(tx_bytes[i], with_first && i == 0, i == tx_bytes.size() - 1);
      end
      tx_count++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_words != 0);
   endtask

   task automatic add_field();
      int pick;
      int len;
      pick = $urandom_range(0, 99);
      len = 0;
      if (pick < 30) begin
         list_payload.push_back(8'($urandom_range(0, SINGLE_MAX)));
      end else begin
         if (pick < 60) begin
            len = $urandom_range(0, 6);
            list_payload.push_back(STR_BASE + 8'(len));
         end else if (pick < 65) begin
            len = $urandom_range(7, 55);
            list_payload.push_back(STR_BASE + 8'(len));
         end else if (pick < 75) begin
            len = $urandom_range(56, 64);
            if ($urandom_range(0, 3) == 0) begin
               list_payload.push_back(SHORT_STR_MAX + 8'd2);
               list_payload.push_back(8'h00);
            end else begin
               list_payload.push_back(SHORT_STR_MAX + 8'd1);
            end
            list_payload.push_back(8'(len));
         end else if (pick < 92) begin
            len = $urandom_range(0, 8);
            list_payload.push_back(LIST_BASE + 8'(len));
         end else begin
            len = $urandom_range(56, 60);
            list_payload.push_back(SHORT_LIST_MAX + 8'd1);
            list_payload.push_back(8'(len));
         end
         repeat (len) list_payload.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic build_tx();
      int kind_pick;
      int need;
      int nfields;
      int mut;
      int n;
      int cut;
      int k;
      tx_bytes.delete();
      list_payload.delete();
      kind_pick = $urandom_range(0, 2);
      need = (kind_pick == 0) ? LEGACY_FIELDS : (kind_pick == 2) ? FEE_MARKET_FIELDS : 0;
      mut = $urandom_range(0, 99);
      nfields = (kind_pick == 1) ? $urandom_range(0, 18) : need + $urandom_range(0, 3);
      if (mut < 6 && need > 0) begin
         nfields = $urandom_range(0, need - 1);
      end
      // a length field too wide for the accumulator
      if (mut >= 6 && mut < 10) begin
         list_payload.push_back($urandom_range(0, 1) ? LONG_STR_MAX - 8'd3
                                                     : SHORT_LIST_MAX + 8'd5);
         list_payload.push_back(8'($urandom_range(1, 255)));
         repeat (4) list_payload.push_back(8'($urandom_range(0, 255)));
      end
      repeat (nfields) add_field();
      if (kind_pick == 1) begin
         tx_bytes.push_back(TYPE_ACCESS_LIST);
      end else if (kind_pick == 2) begin
         tx_bytes.push_back(TYPE_FEE_MARKET);
      end
      n = list_payload.size();
      if (n <= 55 && $urandom_range(0, 7) != 0) begin
         tx_bytes.push_back(LIST_BASE + 8'(n));
      end else if (n <= 255 && $urandom_range(0, 3) != 0) begin
         tx_bytes.push_back(SHORT_LIST_MAX + 8'd1);
         tx_bytes.push_back(8'(n));
      end else begin
         tx_bytes.push_back(SHORT_LIST_MAX + 8'd2);
         tx_bytes.push_back(8'(n >> 8));
         tx_bytes.push_back(8'(n));
      end
      // shrink the declared list so an item runs past it
      if (mut >= 10 && mut < 15 && n > 0) begin
         k = (n < 3) ? n : 3;
         tx_bytes[tx_bytes.size() - 1] = tx_bytes[tx_bytes.size() - 1]
                                         - 8'($urandom_range(1, k));
      end
      foreach (list_payload[i]) tx_bytes.push_back(list_payload[i]);
      if (mut >= 15 && mut < 20) begin
         repeat ($urandom_range(1, 4)) tx_bytes.push_back(8'($urandom_range(0, 255)));
      end
      if (mut >= 20 && mut < 26) begin
         tx_bytes[$urandom_range(0, tx_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end
      if (mut >= 26 && mut < 32 && tx_bytes.size() > 1) begin
         cut = $urandom_range(1, tx_bytes.size() - 1);
         while (tx_bytes.size() > cut) void'(tx_bytes.pop_back());
      end
   endtask

   initial begin
      logic drained_mid;
      drained_mid = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      tx_bytes = '{STR_BASE};
      send_tx(1'b1);
      tx_bytes = '{LIST_BASE};
      send_tx(1'b1);
      tx_bytes = '{TYPE_ACCESS_LIST, LIST_BASE + 8'd3, 8'h00, SINGLE_MAX, STR_BASE};
      send_tx(1'b1);
      tx_bytes = '{TYPE_FEE_MARKET, LIST_BASE + 8'd1, SHORT_LIST_MAX + 8'd8};
      send_tx(1'b1);
      tx_bytes = '{SHORT_LIST_MAX + 8'd1, 8'd2, LIST_BASE + 8'd1, 8'h05, 8'haa};
      send_tx(1'b1);
      tx_bytes = '{SHORT_LIST_MAX + 8'd1, 8'd8, LONG_STR_MAX - 8'd3,
                   8'h01, 8'h00, 8'h00, 8'h00, 8'h00};
      send_tx(1'b1);
      tx_bytes = '{LIST_BASE + 8'd2, STR_BASE + 8'd1};
      send_tx(1'b1);
      wait_drained();

      while (bytes_sent < TARGET_BYTES) begin
         if (bytes_sent >= TARGET_BYTES - QUIET_BYTES) begin
            quiet <= 1'b1;
         end
         if (!drained_mid && bytes_sent >= TARGET_BYTES / 2) begin
            drained_mid = 1'b1;
            wait_drained();
         end
         if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 8)) begin
               put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                        $urandom_range(0, 3) == 0);
               noise_count++;
            end
         end else begin
            build_tx();
            send_tx($urandom_range(0, 9) != 0);
         end
      end
      req_tvalid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("Covered %0d transactions (legacy, access-list, fee-market, broken) and %0d noise bytes.",
               tx_count, noise_count);
      $display("%0d bytes sent, %0d result words compared field by field.",
               bytes_sent, words_checked);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ rlp_transaction_field_tokenizer.f @@
rtl/rlptok_pkg.sv
rtl/rlptok_input_stage.sv
rtl/rlptok_parser.sv
rtl/rlp_transaction_field_tokenizer.sv
tb/rlptok_token_checker.sv
tb/testbench.sv
